FILE: sv/cea_pkg.sv
package cea_pkg;

  localparam int MAX_EXTENTS_DEF = 64;
  localparam int ADDR_BITS_DEF   = 24;
  localparam int POOL_RESET      = 10000;
  localparam int COUNT_OUT_W     = 7;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_COMPACT,
    S_APPEND,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic init;
    logic load;
    logic scan;
    logic decide;
    logic compact;
    logic append;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic quick;
    logic sweep_done;
    logic fail;
    logic out_free;
  } stat_t;

endpackage

FILE: sv/cea_ctrl.sv
module cea_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cea_pkg::stat_t stat,
  output cea_pkg::cmd_t  cmd
);
  import cea_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:    state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) state_nxt = stat.quick ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        if (stat.sweep_done) state_nxt = S_DECIDE;
      end
      S_DECIDE:  state_nxt = stat.fail ? S_DONE : S_COMPACT;
      S_COMPACT: begin
        if (stat.sweep_done) state_nxt = S_APPEND;
      end
      S_APPEND:  state_nxt = S_DONE;
      S_DONE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.init    = (state_r == S_INIT);
    cmd.load    = (state_r == S_IDLE) && in_valid;
    cmd.scan    = (state_r == S_SCAN);
    cmd.decide  = (state_r == S_DECIDE);
    cmd.compact = (state_r == S_COMPACT);
    cmd.append  = (state_r == S_APPEND);
    cmd.finish  = (state_r == S_DONE) && stat.out_free;
    in_stall    = (state_r != S_IDLE);
  end

endmodule

FILE: sv/cea_dp.sv
module cea_dp #(
  parameter int MAX_EXTENTS = cea_pkg::MAX_EXTENTS_DEF,
  parameter int ADDR_BITS   = cea_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cea_pkg::cmd_t                   cmd,
  output cea_pkg::stat_t                  stat,
  input  logic [1:0]                      in_operation,
  input  logic [ADDR_BITS-1:0]            in_block_address,
  input  logic [ADDR_BITS:0]              in_segment_count,
  input  logic                            cfg_we,
  input  logic [ADDR_BITS:0]              cfg_pool_segments,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_status,
  output logic [ADDR_BITS-1:0]            out_granted_address,
  output logic [cea_pkg::COUNT_OUT_W-1:0] out_extents_now,
  output logic [cea_pkg::COUNT_OUT_W-1:0] out_peak_extents
);
  import cea_pkg::*;

  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int AW = ADDR_BITS;
  localparam int LW = ADDR_BITS + 1;
  localparam int SW = ADDR_BITS + 2;

  // free extent table
  logic [AW-1:0] mem_start [MAX_EXTENTS];
  logic [LW-1:0] mem_len   [MAX_EXTENTS];
  logic [AW-1:0] rs_q;
  logic [LW-1:0] rl_q;

  logic [LW-1:0] pool_r, cap, lim;
  op_t           op_r;
  logic [AW-1:0] addr_r;
  logic [LW-1:0] cnt_r;
  logic [CW-1:0] total_r, peak_r;

  logic [CW-1:0] iss_r;
  logic          rdv_r;
  logic [IW-1:0] tag_r;
  logic          issuing;

  logic          found_r, has_lo_r, has_hi_r, dup_r;
  logic [IW-1:0] best_idx_r, lo_idx_r, hi_idx_r;
  logic [AW-1:0] best_start_r, lo_start_r, hi_start_r;
  logic [LW-1:0] best_len_r, lo_len_r, hi_len_r;

  logic [IW-1:0] k2_r;
  logic          two_r, app_r;
  logic [CW-1:0] wr_ptr_r;
  logic [AW-1:0] app_start_r;
  logic [LW-1:0] app_len_r;
  status_t       status_r;
  logic [AW-1:0] granted_r;

  logic          out_valid_r;
  status_t       out_status_r;
  logic [AW-1:0] out_granted_r;
  logic [CW-1:0] out_now_r, out_peak_r;

  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [AW-1:0] wr_s;
  logic [LW-1:0] wr_l;

  logic [SW-1:0] in_end;
  logic          in_bad, in_quick;

  status_t       dec_status;
  logic [AW-1:0] dec_granted;
  logic          dec_drop, dec_two, dec_app;
  logic [IW-1:0] dec_k1, dec_k2;
  logic [AW-1:0] dec_as;
  logic [LW-1:0] dec_al;
  logic [SW-1:0] lo_end, a_end;
  logic          lo_t, hi_t;
  logic [CW-1:0] tot_nxt;

  assign cap = LW'(1) << ADDR_BITS;
  assign lim = (pool_r > cap) ? cap : pool_r;

  assign in_end   = SW'(in_block_address) + SW'(in_segment_count);
  assign in_bad   = (in_operation != OP_ALLOC && in_operation != OP_RELEASE)
                    || (in_segment_count == '0)
                    || (in_operation == OP_RELEASE && in_end > SW'(lim));
  assign in_quick = (in_operation == OP_RESTART) || in_bad;

  assign issuing  = (cmd.scan || cmd.compact) && (iss_r < total_r);

  assign stat.quick      = in_quick;
  assign stat.sweep_done = !rdv_r && (iss_r >= total_r);
  assign stat.fail       = (dec_status != ST_OK);
  assign stat.out_free   = !out_valid_r || !out_stall;

  // table write port
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = '0;
    wr_s   = '0;
    wr_l   = lim;
    if (cmd.init || (cmd.load && in_operation == OP_RESTART && lim != '0)) begin
      wr_en = 1'b1;
    end else if (cmd.compact && rdv_r && !(two_r && tag_r == k2_r)) begin
      wr_en  = 1'b1;
      wr_idx = wr_ptr_r[IW-1:0];
      wr_s   = rs_q;
      wr_l   = rl_q;
    end else if (cmd.append && app_r) begin
      wr_en  = 1'b1;
      wr_idx = wr_ptr_r[IW-1:0];
      wr_s   = app_start_r;
      wr_l   = app_len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_start[wr_idx] <= wr_s;
      mem_len[wr_idx]   <= wr_l;
    end
    if (issuing) begin
      rs_q <= mem_start[iss_r[IW-1:0]];
      rl_q <= mem_len[iss_r[IW-1:0]];
    end
  end

  // outcome of the scan
  always_comb begin
    lo_end      = SW'(lo_start_r) + SW'(lo_len_r);
    a_end       = SW'(addr_r) + SW'(cnt_r);
    lo_t        = has_lo_r && (lo_end == SW'(addr_r));
    hi_t        = has_hi_r && (a_end == SW'(hi_start_r));
    dec_status  = ST_OK;
    dec_granted = '0;
    dec_drop    = 1'b0;
    dec_two     = 1'b0;
    dec_app     = 1'b0;
    dec_k1      = best_idx_r;
    dec_k2      = best_idx_r;
    dec_as      = addr_r;
    dec_al      = cnt_r;
    if (op_r == OP_ALLOC) begin
      if (!found_r) begin
        dec_status = ST_NOFIT;
      end else begin
        dec_granted = best_start_r;
        dec_drop    = 1'b1;
        dec_app     = (best_len_r > cnt_r);
        dec_as      = best_start_r + AW'(cnt_r);
        dec_al      = best_len_r - cnt_r;
      end
    end else begin
      if (dup_r || (has_lo_r && lo_end > SW'(addr_r))
          || (has_hi_r && a_end > SW'(hi_start_r))) begin
        dec_status = ST_BAD;
      end else if (!lo_t && !hi_t && total_r >= CW'(MAX_EXTENTS)) begin
        dec_status = ST_FULL;
      end else begin
        dec_app = 1'b1;
        if (lo_t) dec_as = lo_start_r;
        dec_al = LW'(SW'(cnt_r) + (lo_t ? SW'(lo_len_r) : '0)
                 + (hi_t ? SW'(hi_len_r) : '0));
        dec_drop = lo_t || hi_t;
        dec_two  = lo_t && hi_t;
        if (lo_t && hi_t) begin
          dec_k1 = (lo_idx_r < hi_idx_r) ? lo_idx_r : hi_idx_r;
          dec_k2 = (lo_idx_r < hi_idx_r) ? hi_idx_r : lo_idx_r;
        end else begin
          dec_k1 = lo_t ? lo_idx_r : hi_idx_r;
          dec_k2 = dec_k1;
        end
      end
    end
  end

  assign tot_nxt = wr_ptr_r + CW'(app_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r      <= LW'(POOL_RESET);
      total_r     <= CW'(1);
      peak_r      <= CW'(1);
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) pool_r <= cfg_pool_segments;
      rdv_r <= issuing;
      if (cmd.load && in_operation == OP_RESTART) begin
        total_r <= (lim != '0) ? CW'(1) : '0;
        peak_r  <= (lim != '0) ? CW'(1) : '0;
      end
      if (cmd.append) begin
        total_r <= tot_nxt;
        if (tot_nxt > peak_r) peak_r <= tot_nxt;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issuing) begin
      iss_r <= iss_r + CW'(1);
      tag_r <= iss_r[IW-1:0];
    end
    if (cmd.load) begin
      op_r      <= op_t'(in_operation);
      addr_r    <= in_block_address;
      cnt_r     <= in_segment_count;
      iss_r     <= '0;
      found_r   <= 1'b0;
      has_lo_r  <= 1'b0;
      has_hi_r  <= 1'b0;
      dup_r     <= 1'b0;
      granted_r <= '0;
      status_r  <= (in_operation == OP_RESTART) ? ST_OK : ST_BAD;
    end
    // evaluate one entry per cycle as its read data lands
    if (cmd.scan && rdv_r) begin
      if (op_r == OP_ALLOC) begin
        if (rl_q >= cnt_r && (!found_r || rl_q < best_len_r)) begin
          found_r      <= 1'b1;
          best_idx_r   <= tag_r;
          best_start_r <= rs_q;
          best_len_r   <= rl_q;
        end
      end else begin
        if (rs_q == addr_r) dup_r <= 1'b1;
        if (rs_q < addr_r && (!has_lo_r || rs_q > lo_start_r)) begin
          has_lo_r   <= 1'b1;
          lo_idx_r   <= tag_r;
          lo_start_r <= rs_q;
          lo_len_r   <= rl_q;
        end
        if (rs_q > addr_r && (!has_hi_r || rs_q < hi_start_r)) begin
          has_hi_r   <= 1'b1;
          hi_idx_r   <= tag_r;
          hi_start_r <= rs_q;
          hi_len_r   <= rl_q;
        end
      end
    end
    if (cmd.decide) begin
      status_r    <= dec_status;
      granted_r   <= dec_granted;
      two_r       <= dec_two;
      k2_r        <= dec_k2;
      app_r       <= dec_app;
      app_start_r <= dec_as;
      app_len_r   <= dec_al;
      if (dec_drop) begin
        wr_ptr_r <= CW'(dec_k1);
        iss_r    <= CW'(dec_k1) + CW'(1);
      end else begin
        wr_ptr_r <= total_r;
        iss_r    <= total_r;
      end
    end
    if (cmd.compact && rdv_r && !(two_r && tag_r == k2_r)) begin
      wr_ptr_r <= wr_ptr_r + CW'(1);
    end
    if (cmd.finish) begin
      out_status_r  <= status_r;
      out_granted_r <= granted_r;
      out_now_r     <= total_r;
      out_peak_r    <= peak_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_granted_r;
  assign out_extents_now     = COUNT_OUT_W'(out_now_r);
  assign out_peak_extents    = COUNT_OUT_W'(out_peak_r);

endmodule

FILE: sv/coalescing_extent_allocator_unit.sv
// Channel   Direction  Handshake          Beat contents
// in_       in         in_valid/in_stall  operation, block_address, segment_count
// out_      out        out_valid/out_stall status, granted_address, extents_now,
//                                          peak_extents
// cfg_      in         cfg_we             pool_segments
//
// Restart, a zero count, a release past the pool and an unknown operation skip
// the scan and go straight to the result. Allocate and release scan the table,
// one table read a cycle on the single read port, then read again for the entries
// that close up behind a removed extent, then append; a refused request stops
// after the scan. After reset the init state writes the initial extent with in_stall high.
// A result beat waits in the output register; in_stall drops once it is loaded.
module coalescing_extent_allocator_unit #(
  parameter int MAX_EXTENTS = cea_pkg::MAX_EXTENTS_DEF,
  parameter int ADDR_BITS   = cea_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_operation,
  input  logic [ADDR_BITS-1:0]            in_block_address,
  input  logic [ADDR_BITS:0]              in_segment_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_status,
  output logic [ADDR_BITS-1:0]            out_granted_address,
  output logic [cea_pkg::COUNT_OUT_W-1:0] out_extents_now,
  output logic [cea_pkg::COUNT_OUT_W-1:0] out_peak_extents,
  input  logic                            cfg_we,
  input  logic [ADDR_BITS:0]              cfg_pool_segments
);
  import cea_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: load, scan, decide, close up, append, deliver
  cea_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // extent table, scan trackers, counts and output register
  cea_dp #(
    .MAX_EXTENTS (MAX_EXTENTS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_operation        (in_operation),
    .in_block_address    (in_block_address),
    .in_segment_count    (in_segment_count),
    .cfg_we              (cfg_we),
    .cfg_pool_segments   (cfg_pool_segments),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_granted_address (out_granted_address),
    .out_extents_now     (out_extents_now),
    .out_peak_extents    (out_peak_extents)
  );

endmodule

FILE: dv/testbench.sv
module testbench;
  import cea_pkg::*;

  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int TABLE_DEPTH = MAX_EXTENTS_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 200;

  typedef struct {
    status_t        status;
    logic [23:0]    granted;
    logic [6:0]     now;
    logic [6:0]     peak;
  } beat_t;

  // Free extent table predictor plus queue of outstanding result beats.
  class free_extent_tracker;
    logic [23:0] ext_start[TABLE_DEPTH];
    logic [24:0] ext_len[TABLE_DEPTH];
    int          total;
    int          peak;
    logic [24:0] pool;
    beat_t       pending[$];
    int          errors;

    function new();
      pool = 25'(POOL_RESET);
      errors = 0;
      restart();
    endfunction

    function logic [25:0] limit();
      return (pool > 25'h1000000) ? 26'h1000000 : {1'b0, pool};
    endfunction

    function void append(logic [23:0] s, logic [24:0] l);
      if (total >= TABLE_DEPTH) return;
      ext_start[total] = s;
      ext_len[total] = l;
      total++;
      if (total > peak) peak = total;
    endfunction

    function void drop(int i);
      for (int j = i; j < total - 1; j++) begin
        ext_start[j] = ext_start[j+1];
        ext_len[j] = ext_len[j+1];
      end
      total--;
    endfunction

    function void restart();
      logic [25:0] lim;
      lim = limit();
      total = 0;
      peak = 0;
      if (lim > 0) append('0, lim[24:0]);
    endfunction

    function status_t grab(logic [24:0] n, output logic [23:0] g);
      int best;
      logic [23:0] s;
      logic [24:0] l;
      best = -1;
      g = '0;
      if (n == 0) return ST_BAD;
      for (int i = 0; i < total; i++)
        if (ext_len[i] >= n && (best < 0 || ext_len[i] < ext_len[best])) best = i;
      if (best < 0) return ST_NOFIT;
      s = ext_start[best];
      l = ext_len[best];
      drop(best);
      if (l > n) append(s + n[23:0], l - n);
      g = s;
      return ST_OK;
    endfunction

    function status_t give_back(logic [23:0] a, logic [24:0] n);
      int lo, hi;
      logic [25:0] a_end;
      logic lo_touch, hi_touch;
      logic [23:0] ns;
      logic [25:0] nl;
      lo = -1;
      hi = -1;
      a_end = a + n;
      if (n == 0 || a_end > limit()) return ST_BAD;
      for (int i = 0; i < total; i++) begin
        if (ext_start[i] == a) return ST_BAD;
        if (ext_start[i] < a && (lo < 0 || ext_start[i] > ext_start[lo])) lo = i;
        if (ext_start[i] > a && (hi < 0 || ext_start[i] < ext_start[hi])) hi = i;
      end
      if (lo >= 0 && ext_start[lo] + 26'(ext_len[lo]) > a) return ST_BAD;
      if (hi >= 0 && a_end > ext_start[hi]) return ST_BAD;
      lo_touch = lo >= 0 && ext_start[lo] + 26'(ext_len[lo]) == a;
      hi_touch = hi >= 0 && a_end == ext_start[hi];
      if (!lo_touch && !hi_touch && total >= TABLE_DEPTH) return ST_FULL;
      ns = a;
      nl = 26'(n);
      if (lo_touch) begin
        ns = ext_start[lo];
        nl += ext_len[lo];
      end
      if (hi_touch) nl += ext_len[hi];
      if (lo_touch && hi_touch) begin
        drop(lo > hi ? lo : hi);
        drop(lo > hi ? hi : lo);
      end else if (lo_touch) drop(lo);
      else if (hi_touch) drop(hi);
      append(ns, nl[24:0]);
      return ST_OK;
    endfunction

    function beat_t note_request(logic [1:0] op, logic [23:0] a, logic [24:0] n);
      beat_t b;
      b.granted = '0;
      case (op)
        OP_ALLOC:   b.status = grab(n, b.granted);
        OP_RELEASE: b.status = give_back(a, n);
        OP_RESTART: begin
          restart();
          b.status = ST_OK;
        end
        default:    b.status = ST_BAD;
      endcase
      if (b.status != ST_OK) b.granted = '0;
      b.now = total[6:0];
      b.peak = peak[6:0];
      pending.insert(pending.size(), b);
      return b;
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat, status %0d", $time, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.granted !== want.granted) begin
        $display("%0t: granted_address expected %0h actual %0h", $time, want.granted,
                 got.granted);
        errors++;
      end
      if (got.now !== want.now) begin
        $display("%0t: extents_now expected %0d actual %0d", $time, want.now, got.now);
        errors++;
      end
      if (got.peak !== want.peak) begin
        $display("%0t: peak_extents expected %0d actual %0d", $time, want.peak, got.peak);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_operation = '0;
  logic [23:0] in_block_address = '0;
  logic [24:0] in_segment_count = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  out_status;
  logic [23:0] out_granted_address;
  logic [6:0]  out_extents_now;
  logic [6:0]  out_peak_extents;
  logic        cfg_we = 0;
  logic [24:0] cfg_pool_segments = '0;

  free_extent_tracker extents = new();
  // Extents the stimulus believes it holds, so releases can hit real allocations.
  logic [23:0] held_start[$];
  logic [24:0] held_len[$];
  bit          calm = 0;
  int          cycles = 0;

  always #5 clk = ~clk;

  coalescing_extent_allocator_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_block_address(in_block_address),
    .in_segment_count(in_segment_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_granted_address(out_granted_address),
    .out_extents_now(out_extents_now), .out_peak_extents(out_peak_extents),
    .cfg_we(cfg_we), .cfg_pool_segments(cfg_pool_segments)
  );

  // Stall the result side at random, except during the calm stretch.
  always @(negedge clk) out_stall <= !calm && $urandom_range(0, 99) < 10;

  // Check every accepted result beat and bound the run length.
  always @(posedge clk) begin
    beat_t got;
    cycles++;
    if (rst_n && out_valid && !out_stall) begin
      got.status = status_t'(out_status);
      got.granted = out_granted_address;
      got.now = out_extents_now;
      got.peak = out_peak_extents;
      extents.check_beat(got);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Present one request beat and hold it until accepted; idle first at random.
  task automatic send(input logic [1:0] op, input logic [23:0] a, input logic [24:0] n);
    beat_t r;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1;
    in_operation <= op;
    in_block_address <= a;
    in_segment_count <= n;
    do @(posedge clk); while (in_stall);
    r = extents.note_request(op, a, n);
    // Track what we now hold, so later releases return real allocations.
    if (op == OP_RESTART) begin
      held_start.delete();
      held_len.delete();
    end else if (op == OP_ALLOC && r.status == ST_OK) begin
      held_start.push_back(r.granted);
      held_len.push_back(n);
    end
  endtask

  // Hold off the sender until every outstanding beat has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (extents.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_pool(input logic [24:0] v);
    drain();
    @(negedge clk);
    cfg_we <= 1;
    cfg_pool_segments <= v;
    @(negedge clk);
    cfg_we <= 0;
    extents.pool = v;
    send(OP_RESTART, '0, '0);
  endtask

  // Return part or all of a held extent: the front of it goes back.
  task automatic release_held();
    int k;
    logic [24:0] m;
    logic [23:0] s;
    k = $urandom_range(0, held_start.size() - 1);
    s = held_start[k];
    m = ($urandom_range(0, 2) == 0) ? 25'($urandom_range(1, held_len[k])) : held_len[k];
    send(OP_RELEASE, s, m);
    if (extents.pending[$].status == ST_OK) begin
      if (m == held_len[k]) begin
        held_start.delete(k);
        held_len.delete(k);
      end else begin
        held_start[k] = s + m[23:0];
        held_len[k] = held_len[k] - m;
      end
    end
  endtask

  task automatic random_item();
    int pick;
    logic [25:0] lim;
    pick = $urandom_range(0, 99);
    lim = extents.limit();
    if (pick < 45 || (pick < 85 && held_start.size() == 0)) begin
      if ($urandom_range(0, 9) == 0 && lim > 1)
        send(OP_ALLOC, '0, 25'($urandom_range(1, lim)));
      else
        send(OP_ALLOC, '0, 25'($urandom_range(1, 64)));
    end else if (pick < 85) release_held();
    else if (pick < 90)
      send(OP_RELEASE, 24'($urandom), 25'($urandom_range(0, 99)));
    else if (pick < 92) send(OP_RESTART, 24'($urandom), 25'($urandom));
    else if (pick < 94) send(2'($urandom_range(0, 1)), 24'($urandom), '0);
    else if (pick < 96) send(OP_UNKNOWN, 24'($urandom), 25'($urandom));
    else send(2'($urandom_range(0, 1)), 24'($urandom), 25'($urandom));
  endtask

  initial begin
    logic [24:0] pools[6];
    pools = '{25'd1, 25'h1000000, 25'd0, 25'd300, 25'h1FFFFFF, 25'd5000};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: reset pool, bad counts, exact fit, misfit, double free, bounds.
    send(OP_ALLOC, '0, '0);
    send(OP_ALLOC, '0, 25'd1);
    send(OP_ALLOC, '0, 25'd5000);
    send(OP_ALLOC, '0, 25'd20000);
    send(OP_RELEASE, 24'd0, 25'd1);
    send(OP_RELEASE, 24'd0, 25'd1);
    send(OP_RELEASE, 24'd0, '0);
    send(OP_RELEASE, 24'hFFFFFF, 25'd1);
    send(OP_RELEASE, 24'd9999, 25'd2);
    send(OP_UNKNOWN, 24'hFFFFFF, 25'h1FFFFFF);
    send(OP_ALLOC, '0, 25'h1FFFFFF);
    send(OP_ALLOC, '0, 25'd4999);
    send(OP_RELEASE, 24'd1, 25'd5000);
    send(OP_RESTART, '0, '0);

    // Fragment the table until releases report it full.
    for (int i = 0; i < 140; i++) send(OP_ALLOC, '0, 25'd1);
    for (int i = 0; i < 140; i += 2) send(OP_RELEASE, 24'(i), 25'd1);
    send(OP_RELEASE, 24'd1, 25'd1);

    for (int p = 0; p < 6; p++) begin
      set_pool(pools[p]);
      if (pools[p] == 25'h1000000) begin
        send(OP_ALLOC, '0, 25'h1000000);
        send(OP_RELEASE, 24'hFFFFFF, 25'd1);
        send(OP_RELEASE, 24'd0, 25'hFFFFFF);
      end
      for (int i = 0; i < 280; i++) begin
        calm = (p == 3 && i >= 50 && i < 200);
        if (p == 5 && i == 120) drain();
        random_item();
      end
      calm = 0;
    end

    drain();
    if (extents.errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule

FILE: coalescing_extent_allocator_unit.f
sv/cea_pkg.sv
sv/cea_ctrl.sv
sv/cea_dp.sv
sv/coalescing_extent_allocator_unit.sv
dv/testbench.sv
